// ===== src/ufd_pkg.sv =====
// ----------------------------------------------------------------------------
// Finish detector package
// Shared widths, phase codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package ufd_pkg;

	// lanes with sensor ports
	localparam int unsigned LANES     = 2;
	localparam int unsigned PHASE_W   = 3;
	localparam int unsigned TIMER_W   = 16;
	localparam int unsigned TIME_W    = 32;
	localparam int unsigned SETTLE_W  = 8;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = 16;

	// lane phase codes
	localparam logic [PHASE_W-1:0] PH_SETTLE  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_TRIGGER = 3'd1;
	localparam logic [PHASE_W-1:0] PH_WAIT    = 3'd2;
	localparam logic [PHASE_W-1:0] PH_MEASURE = 3'd3;
	localparam logic [PHASE_W-1:0] PH_DONE    = 3'd4;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAIT_LIM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_LIM  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIM = 2'd3;

	// configuration reset values
	localparam logic [SETTLE_W-1:0] SETTLE_RST    = 8'd25;
	localparam logic [TIMER_W-1:0]  WAIT_LIM_RST  = 16'd1000;
	localparam logic [TIMER_W-1:0]  HIGH_LIM_RST  = 16'd4000;
	localparam logic [TIMER_W-1:0]  RANGE_LIM_RST = 16'd9860;

	localparam logic [TIME_W-1:0] TIME_MAX = '1;

endpackage

// ===== src/ufd_if.sv =====
// ----------------------------------------------------------------------------
// Finish detector channels
// Valid/ready channels for the tick samples and the per-tick status.
// ----------------------------------------------------------------------------
interface ufd_sample_if;
	logic valid;
	logic ready;
	logic echo_a;
	logic echo_b;
	logic start_race;

	modport source (output valid, output echo_a, output echo_b, output start_race,
		input ready);
	modport sink (input valid, input echo_a, input echo_b, input start_race,
		output ready);
endinterface

interface ufd_status_if import ufd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              trig_a;
	logic              trig_b;
	logic              done_a;
	logic              done_b;
	logic [TIME_W-1:0] time_a;
	logic [TIME_W-1:0] time_b;
	logic              both_done;

	modport source (output valid, output trig_a, output trig_b, output done_a,
		output done_b, output time_a, output time_b, output both_done, input ready);
	modport sink (input valid, input trig_a, input trig_b, input done_a,
		input done_b, input time_a, input time_b, input both_done, output ready);
endinterface

// ===== src/dual_ultrasonic_finish_detector.sv =====
// ----------------------------------------------------------------------------
// Dual ultrasonic finish detector
// Two ranging lanes, each confirming a finish after two in-range echoes.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  ---------+-----------+----------------------------------------------------
//  sample   | in        | echo_a, echo_b, start_race (one request per tick)
//  status   | out       | trig_a/b, done_a/b, time_a/b, both_done
//  cfg      | in        | write enable, 2-bit index, 16-bit data
//
// One request is taken per cycle while sample.ready is high; its status appears in the next cycle.
// The lane state update and the status register form the only stage.
// sample.ready is high while the status register is empty or being drained,
// so a stalled status holds one result and blocks only further requests.
// Reset clears all lane state and loads the default limits.
// ----------------------------------------------------------------------------
module dual_ultrasonic_finish_detector import ufd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	ufd_sample_if.sink           sample,
	ufd_status_if.source         status,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	logic [SETTLE_W-1:0] settle_q;
	logic [TIMER_W-1:0]  wait_lim_q;
	logic [TIMER_W-1:0]  high_lim_q;
	logic [TIMER_W-1:0]  range_lim_q;

	logic [PHASE_W-1:0] lane_phase_q [LANES];
	logic [TIMER_W-1:0] lane_timer_q [LANES];
	logic               lane_hit_q   [LANES];
	logic [TIME_W-1:0]  lane_time_q  [LANES];
	logic [TIME_W-1:0]  elapsed_q;

	logic [PHASE_W-1:0] phase_nx [LANES];
	logic [TIMER_W-1:0] timer_nx [LANES];
	logic               hit_nx   [LANES];
	logic [TIME_W-1:0]  time_nx  [LANES];
	logic [TIME_W-1:0]  elapsed_nx;
	logic [LANES-1:0]   echo_v;
	logic [LANES-1:0]   trig_nx;
	logic [LANES-1:0]   done_nx;
	logic [TIMER_W-1:0] inc_t;

	logic status_valid_q;
	logic accept;

	assign sample.ready = !status_valid_q || status.ready;
	assign accept       = sample.valid && sample.ready;
	assign echo_v       = {sample.echo_b, sample.echo_a};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q    <= SETTLE_RST;
			wait_lim_q  <= WAIT_LIM_RST;
			high_lim_q  <= HIGH_LIM_RST;
			range_lim_q <= RANGE_LIM_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETTLE:    settle_q    <= cfg_data[SETTLE_W-1:0];
				REG_WAIT_LIM:  wait_lim_q  <= cfg_data;
				REG_HIGH_LIM:  high_lim_q  <= cfg_data;
				REG_RANGE_LIM: range_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance elapsed count, saturating; a start request clears it
	always_comb begin
		if (sample.start_race) begin
			elapsed_nx = '0;
		end else if (elapsed_q == TIME_MAX) begin
			elapsed_nx = elapsed_q;
		end else begin
			elapsed_nx = elapsed_q + TIME_W'(1);
		end
	end

	// advance each lane by one tick
	always_comb begin
		inc_t = '0;
		for (int k = 0; k < LANES; k++) begin
			phase_nx[k] = lane_phase_q[k];
			timer_nx[k] = lane_timer_q[k];
			hit_nx[k]   = lane_hit_q[k];
			time_nx[k]  = lane_time_q[k];
			inc_t       = lane_timer_q[k] + TIMER_W'(1);
			if (sample.start_race) begin
				phase_nx[k] = PH_SETTLE;
				timer_nx[k] = '0;
				hit_nx[k]   = 1'b0;
				time_nx[k]  = '0;
			end else begin
				case (lane_phase_q[k])
					PH_SETTLE: begin
						if (lane_timer_q[k] < {{(TIMER_W-SETTLE_W){1'b0}}, settle_q}) begin
							timer_nx[k] = inc_t;
						end else begin
							timer_nx[k] = '0;
							phase_nx[k] = PH_TRIGGER;
						end
					end
					PH_TRIGGER: begin
						timer_nx[k] = '0;
						phase_nx[k] = PH_WAIT;
					end
					PH_WAIT: begin
						if (echo_v[k]) begin
							timer_nx[k] = '0;
							phase_nx[k] = PH_MEASURE;
						end else if (lane_timer_q[k] >= wait_lim_q) begin
							timer_nx[k] = '0;
							phase_nx[k] = PH_SETTLE;
						end else begin
							timer_nx[k] = inc_t;
						end
					end
					PH_MEASURE: begin
						if (!echo_v[k]) begin
							// echo ended: judge its width
							timer_nx[k] = '0;
							phase_nx[k] = PH_SETTLE;
							if (lane_timer_q[k] <= range_lim_q) begin
								if (lane_hit_q[k]) begin
									time_nx[k]  = elapsed_nx;
									phase_nx[k] = PH_DONE;
								end else begin
									hit_nx[k] = 1'b1;
								end
							end else begin
								hit_nx[k] = 1'b0;
							end
						end else if (inc_t >= high_lim_q) begin
							// echo too long: abandon
							timer_nx[k] = '0;
							hit_nx[k]   = 1'b0;
							phase_nx[k] = PH_SETTLE;
						end else begin
							timer_nx[k] = inc_t;
						end
					end
					PH_DONE: ;
					default: begin
						timer_nx[k] = '0;
						phase_nx[k] = PH_SETTLE;
					end
				endcase
			end
			trig_nx[k] = phase_nx[k] inside {[PH_TRIGGER:PH_DONE]};
			done_nx[k] = (phase_nx[k] == PH_DONE);
		end
	end

	// hold lane state, update on each request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elapsed_q <= '0;
			for (int k = 0; k < LANES; k++) begin
				lane_phase_q[k] <= PH_SETTLE;
				lane_timer_q[k] <= '0;
				lane_hit_q[k]   <= 1'b0;
				lane_time_q[k]  <= '0;
			end
		end else if (accept) begin
			elapsed_q <= elapsed_nx;
			for (int k = 0; k < LANES; k++) begin
				lane_phase_q[k] <= phase_nx[k];
				lane_timer_q[k] <= timer_nx[k];
				lane_hit_q[k]   <= hit_nx[k];
				lane_time_q[k]  <= time_nx[k];
			end
		end
	end

	// status register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_valid_q <= 1'b0;
		end else if (accept) begin
			status_valid_q <= 1'b1;
		end else if (status.ready) begin
			status_valid_q <= 1'b0;
		end
	end

	// status payload
	always_ff @(posedge clk) begin
		if (accept) begin
			status.trig_a    <= trig_nx[0];
			status.trig_b    <= trig_nx[1];
			status.done_a    <= done_nx[0];
			status.done_b    <= done_nx[1];
			status.time_a    <= time_nx[0];
			status.time_b    <= time_nx[1];
			status.both_done <= &done_nx;
		end
	end

	assign status.valid = status_valid_q;

	// a start request always clears the elapsed count
	a_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && sample.start_race |=> elapsed_q == '0)
		else $error("elapsed count not cleared by start");

	// every accepted request yields a pending status
	a_status_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> status_valid_q)
		else $error("status missing after request");

	for (genvar g = 0; g < LANES; g++) begin : g_lane_chk
		// only a start request leaves the finished phase
		a_done_holds: assert property (@(posedge clk) disable iff (!arst_n)
			lane_phase_q[g] == PH_DONE && !(accept && sample.start_race)
			|=> lane_phase_q[g] == PH_DONE)
			else $error("lane left done without start");

		// finish time stays clear until the lane finishes
		a_time_clear: assert property (@(posedge clk) disable iff (!arst_n)
			lane_phase_q[g] != PH_DONE |-> lane_time_q[g] == '0)
			else $error("finish time set while not done");
	end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Finish detector testbench
// Drives microsecond ticks with random echo bursts into both lanes, keeps its
// own copy of the lane state and limits, and checks every status word.
// ----------------------------------------------------------------------------
module tb_top;
	import ufd_pkg::*;

	typedef struct packed {
		logic              trig_a;
		logic              trig_b;
		logic              done_a;
		logic              done_b;
		logic [TIME_W-1:0] time_a;
		logic [TIME_W-1:0] time_b;
		logic              both_done;
	} status_t;

	typedef struct packed {
		logic [SETTLE_W-1:0] settle;
		logic [TIMER_W-1:0]  wait_lim;
		logic [TIMER_W-1:0]  high_lim;
		logic [TIMER_W-1:0]  range_lim;
	} limits_t;

	typedef enum logic {ROW_TICK, ROW_LIMITS} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		logic      echo_a;
		logic      echo_b;
		logic      start;
		logic      fixed;
		status_t   want;
		limits_t   limits;
	} row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	ufd_sample_if sample_ch ();
	ufd_status_if status_ch ();

	dual_ultrasonic_finish_detector uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample    (sample_ch),
		.status    (status_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lane state and limits as the block should hold them
	logic [PHASE_W-1:0]  lane_ph    [LANES];
	logic [TIMER_W-1:0]  lane_count [LANES];
	logic                lane_armed [LANES];
	logic [TIME_W-1:0]   lap_time   [LANES];
	logic [TIME_W-1:0]   race_ticks;
	logic [SETTLE_W-1:0] settle_cfg;
	logic [TIMER_W-1:0]  wait_cfg;
	logic [TIMER_W-1:0]  high_cfg;
	logic [TIMER_W-1:0]  range_cfg;

	status_t     expected_status [$];
	int unsigned mismatches = 0;
	bit          quiet = 1'b0;
	int unsigned stall_left = 0;
	int unsigned ready_roll;

	// echo burst generators, one per lane
	logic        echo_lvl  [LANES];
	int unsigned echo_left [LANES];

	task automatic report(input string msg);
		if (mismatches < 40)
			$display("%0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [TIME_W-1:0] got,
		input logic [TIME_W-1:0] want);
		if (got !== want)
			report($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	// advance both lanes by one tick and return the status they show after it
	function automatic status_t range_tick(input logic ea, input logic eb, input logic st);
		status_t            s;
		logic               echo;
		logic [TIMER_W-1:0] nxt;
		if (st) begin
			for (int k = 0; k < LANES; k++) begin
				lane_ph[k]    = PH_SETTLE;
				lane_count[k] = '0;
				lane_armed[k] = 1'b0;
				lap_time[k]   = '0;
			end
			race_ticks = '0;
		end else begin
			if (race_ticks != TIME_MAX)
				race_ticks = race_ticks + 1'b1;
			for (int k = 0; k < LANES; k++) begin
				echo = (k == 0) ? ea : eb;
				case (lane_ph[k])
					PH_SETTLE: begin
						if (lane_count[k] < TIMER_W'(settle_cfg)) begin
							lane_count[k] = lane_count[k] + 1'b1;
						end else begin
							lane_count[k] = '0;
							lane_ph[k]    = PH_TRIGGER;
						end
					end
					PH_TRIGGER: begin
						lane_count[k] = '0;
						lane_ph[k]    = PH_WAIT;
					end
					PH_WAIT: begin
						if (echo) begin
							lane_count[k] = '0;
							lane_ph[k]    = PH_MEASURE;
						end else if (lane_count[k] >= wait_cfg) begin
							lane_count[k] = '0;
							lane_ph[k]    = PH_SETTLE;
						end else begin
							lane_count[k] = lane_count[k] + 1'b1;
						end
					end
					PH_MEASURE: begin
						if (!echo) begin
							// echo has fallen: the count is its width
							if (lane_count[k] <= range_cfg) begin
								if (lane_armed[k]) begin
									lap_time[k] = race_ticks;
									lane_ph[k]  = PH_DONE;
								end else begin
									lane_armed[k] = 1'b1;
									lane_ph[k]    = PH_SETTLE;
								end
							end else begin
								lane_armed[k] = 1'b0;
								lane_ph[k]    = PH_SETTLE;
							end
							lane_count[k] = '0;
						end else begin
							nxt = lane_count[k] + 1'b1;
							if (nxt >= high_cfg) begin
								lane_count[k] = '0;
								lane_armed[k] = 1'b0;
								lane_ph[k]    = PH_SETTLE;
							end else begin
								lane_count[k] = nxt;
							end
						end
					end
					PH_DONE: begin
					end
					default: begin
						lane_count[k] = '0;
						lane_ph[k]    = PH_SETTLE;
					end
				endcase
			end
		end
		s.trig_a    = (lane_ph[0] >= PH_TRIGGER) && (lane_ph[0] <= PH_DONE);
		s.trig_b    = (lane_ph[1] >= PH_TRIGGER) && (lane_ph[1] <= PH_DONE);
		s.done_a    = (lane_ph[0] == PH_DONE);
		s.done_b    = (lane_ph[1] == PH_DONE);
		s.time_a    = lap_time[0];
		s.time_b    = lap_time[1];
		s.both_done = s.done_a && s.done_b;
		return s;
	endfunction

	// mostly short gaps, a few long ones, none in a quiet phase
	function automatic int unsigned pick_gap();
		int unsigned r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// echo level for one lane: bursts of random width with the odd glitch
	function automatic logic next_echo(input int k);
		logic lvl;
		if (echo_left[k] == 0) begin
			echo_lvl[k] = ~echo_lvl[k];
			if (echo_lvl[k])
				echo_left[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
					: $urandom_range(1, 6);
			else
				echo_left[k] = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 80)
					: $urandom_range(1, 12);
		end
		echo_left[k]--;
		lvl = echo_lvl[k];
		if ($urandom_range(0, 24) == 0)
			lvl = ~lvl;
		return lvl;
	endfunction

	function automatic limits_t make_limits(input logic [SETTLE_W-1:0] settle,
		input logic [TIMER_W-1:0] wait_lim, input logic [TIMER_W-1:0] high_lim,
		input logic [TIMER_W-1:0] range_lim);
		limits_t l;
		l.settle    = settle;
		l.wait_lim  = wait_lim;
		l.high_lim  = high_lim;
		l.range_lim = range_lim;
		return l;
	endfunction

	function automatic row_t tick_row(input logic ea, input logic eb, input logic st);
		row_t r;
		r        = '0;
		r.kind   = ROW_TICK;
		r.echo_a = ea;
		r.echo_b = eb;
		r.start  = st;
		return r;
	endfunction

	// tick whose status is known to be all zero (settle phase or start)
	function automatic row_t zero_row(input logic ea, input logic eb, input logic st);
		row_t r;
		r       = tick_row(ea, eb, st);
		r.fixed = 1'b1;
		return r;
	endfunction

	function automatic row_t limits_row(input limits_t l);
		row_t r;
		r        = '0;
		r.kind   = ROW_LIMITS;
		r.limits = l;
		return r;
	endfunction

	// offer one request, wait for it to be taken, then log its status
	task automatic put_request(input logic ea, input logic eb, input logic st,
		input logic fixed, input status_t want);
		int unsigned gap;
		status_t     predicted;
		gap = pick_gap();
		if (gap > 0) begin
			sample_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.echo_a     <= ea;
		sample_ch.echo_b     <= eb;
		sample_ch.start_race <= st;
		do @(posedge clk); while (!sample_ch.ready);
		predicted = range_tick(ea, eb, st);
		expected_status.push_back(fixed ? want : predicted);
	endtask

	// hold off requests until every status word has come back
	task automatic drain_status();
		sample_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_status.size() != 0);
	endtask

	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_SETTLE:    settle_cfg = data[SETTLE_W-1:0];
			REG_WAIT_LIM:  wait_cfg   = data;
			REG_HIGH_LIM:  high_cfg   = data;
			REG_RANGE_LIM: range_cfg  = data;
			default: begin
			end
		endcase
	endtask

	// rewrite all four limits once the block has gone idle
	task automatic load_limits(input limits_t l);
		drain_status();
		repeat (3) @(posedge clk);
		put_reg(REG_SETTLE, CFG_DAT_W'(l.settle));
		put_reg(REG_WAIT_LIM, l.wait_lim);
		put_reg(REG_HIGH_LIM, l.high_lim);
		put_reg(REG_RANGE_LIM, l.range_lim);
		cfg_we <= 1'b0;
	endtask

	// status sink: random stalls, mostly short, none in a quiet phase
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			status_ch.ready <= 1'b0;
		end else if (quiet) begin
			status_ch.ready <= 1'b1;
		end else begin
			ready_roll = $urandom_range(0, 99);
			if (ready_roll < 70) begin
				status_ch.ready <= 1'b1;
			end else begin
				stall_left = (ready_roll < 95) ? $urandom_range(0, 2) : $urandom_range(8, 40);
				status_ch.ready <= 1'b0;
			end
		end
	end

	// compare every status word taken with the oldest one pending
	always @(posedge clk) begin
		status_t got;
		status_t want;
		if (arst_n && status_ch.valid && status_ch.ready) begin
			got.trig_a    = status_ch.trig_a;
			got.trig_b    = status_ch.trig_b;
			got.done_a    = status_ch.done_a;
			got.done_b    = status_ch.done_b;
			got.time_a    = status_ch.time_a;
			got.time_b    = status_ch.time_b;
			got.both_done = status_ch.both_done;
			if (expected_status.size() == 0) begin
				report("status word with no request pending");
			end else begin
				want = expected_status.pop_front();
				check_field("trig_a", TIME_W'(got.trig_a), TIME_W'(want.trig_a));
				check_field("trig_b", TIME_W'(got.trig_b), TIME_W'(want.trig_b));
				check_field("done_a", TIME_W'(got.done_a), TIME_W'(want.done_a));
				check_field("done_b", TIME_W'(got.done_b), TIME_W'(want.done_b));
				check_field("time_a", got.time_a, want.time_a);
				check_field("time_b", got.time_b, want.time_b);
				check_field("both_done", TIME_W'(got.both_done), TIME_W'(want.both_done));
			end
		end
	end

	initial begin
		#4_000_000;
		$display("tb_top failed");
		$finish;
	end

	initial begin
		row_t        plan [$];
		limits_t     phase_limits [6];
		int unsigned phase_len [6];
		logic        ea;
		logic        eb;
		logic        st;

		sample_ch.valid      <= 1'b0;
		sample_ch.echo_a     <= 1'b0;
		sample_ch.echo_b     <= 1'b0;
		sample_ch.start_race <= 1'b0;
		cfg_we               <= 1'b0;
		cfg_index            <= REG_SETTLE;
		cfg_data             <= '0;
		arst_n               <= 1'b0;

		// reset state of the block
		settle_cfg = SETTLE_RST;
		wait_cfg   = WAIT_LIM_RST;
		high_cfg   = HIGH_LIM_RST;
		range_cfg  = RANGE_LIM_RST;
		race_ticks = '0;
		for (int k = 0; k < LANES; k++) begin
			lane_ph[k]    = PH_SETTLE;
			lane_count[k] = '0;
			lane_armed[k] = 1'b0;
			lap_time[k]   = '0;
			echo_lvl[k]   = 1'b1;
			echo_left[k]  = 0;
		end

		// lane A: two in-range echoes to finish; lane B: wait timeout,
		// echo held past the high limit, then an echo too wide to count
		plan = '{
			zero_row(1'b0, 1'b0, 1'b0),
			zero_row(1'b1, 1'b1, 1'b0),
			zero_row(1'b0, 1'b0, 1'b1),
			limits_row(make_limits(8'd0, 16'd2, 16'd3, 16'd1)),
			zero_row(1'b1, 1'b1, 1'b1),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b1, 1'b0, 1'b0),
			tick_row(1'b1, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			tick_row(1'b1, 1'b1, 1'b0),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b1, 1'b1, 1'b0),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b1, 1'b0, 1'b0),
			tick_row(1'b1, 1'b0, 1'b0),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b0, 1'b1, 1'b0),
			tick_row(1'b0, 1'b0, 1'b0),
			zero_row(1'b0, 1'b0, 1'b1)
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// walk the directed table
		foreach (plan[i]) begin
			if (plan[i].kind == ROW_LIMITS)
				load_limits(plan[i].limits);
			else
				put_request(plan[i].echo_a, plan[i].echo_b, plan[i].start,
					plan[i].fixed, plan[i].want);
		end

		// random phases: defaults, all zero, all ones, then small limits
		phase_limits[0] = make_limits(SETTLE_RST, WAIT_LIM_RST, HIGH_LIM_RST, RANGE_LIM_RST);
		phase_limits[1] = '0;
		phase_limits[2] = '1;
		for (int p = 3; p < 6; p++)
			phase_limits[p] = make_limits(SETTLE_W'($urandom_range(0, 6)),
				TIMER_W'($urandom_range(0, 24)), TIMER_W'($urandom_range(1, 40)),
				TIMER_W'($urandom_range(0, 40)));
		phase_len = '{180, 150, 320, 150, 150, 150};

		for (int p = 0; p < 6; p++) begin
			load_limits(phase_limits[p]);
			quiet = (p == 0) || (p == 3);
			for (int n = 0; n < phase_len[p]; n++) begin
				if (p == 4 && n == 70)
					drain_status();
				ea = next_echo(0);
				eb = next_echo(1);
				st = ($urandom_range(0, 119) == 0);
				put_request(ea, eb, st, 1'b0, '0);
			end
		end

		drain_status();
		repeat (4) @(posedge clk);
		if (mismatches == 0 && expected_status.size() == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
